FILE: src/aft_pkg.sv
`default_nettype none
package aft_pkg;

	typedef enum logic [2:0] {
		M_SKIP    = 3'd0,
		M_LEADCOM = 3'd1,
		M_NAME    = 3'd2,
		M_SPACES  = 3'd3,
		M_PERIOD  = 3'd4,
		M_ESCAPE  = 3'd5,
		M_TAILCOM = 3'd6
	} scan_mode_t;

	localparam logic [2:0] DLM_COLON = 3'd0;
	localparam logic [2:0] DLM_COMMA = 3'd1;
	localparam logic [2:0] DLM_NL    = 3'd2;
	localparam logic [2:0] DLM_SPACE = 3'd3;
	localparam logic [2:0] DLM_TAB   = 3'd4;
	localparam logic [2:0] DLM_EOI   = 3'd5;

	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// what travels with a finished name from the parser to the emitter
	typedef struct packed {
		logic [2:0] delim;
		logic       found;
		logic       trunc;
		logic       bank;
	} job_meta_t;

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
	endfunction

	// mode after a byte seen inside a name
	function automatic scan_mode_t name_next(input logic [7:0] c);
		if (c == CH_COLON || c == CH_COMMA || c == CH_NL) begin
			name_next = M_SKIP;
		end else if (c == CH_PIPE) begin
			name_next = M_TAILCOM;
		end else if (c == CH_PERIOD) begin
			name_next = M_PERIOD;
		end else if (c == CH_BSLASH) begin
			name_next = M_ESCAPE;
		end else if (c == CH_SPACE) begin
			name_next = M_SPACES;
		end else begin
			name_next = M_NAME;
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/aft_parser.sv
`default_nettype none
module aft_parser #(
	parameter int MAX_NAME_CHARS = 32,
	parameter int CW = $clog2(MAX_NAME_CHARS + 1),
	parameter int AW = $clog2(2 * MAX_NAME_CHARS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [7:0]            in_char,
	input  wire logic                  end_of_input,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [7:0]                 wr_data,
	output logic                       fin,
	output logic [CW-1:0]              job_n,
	output aft_pkg::job_meta_t         job_meta
);
	import aft_pkg::*;

	localparam logic [CW-1:0] MAXC = CW'(MAX_NAME_CHARS);
	localparam logic [AW-1:0] BANK_OFS = AW'(MAX_NAME_CHARS);

	scan_mode_t    mode_q, mode_d;
	logic [CW-1:0] kept_q, nb_q;
	logic          ovf_q, bank_q;

	logic          dot_commit, spec_dot, app_en, found;
	logic [2:0]    code;
	logic [CW-1:0] k1, nb1, wr_idx;
	logic          ov1, wr_ok;

	// next scan mode
	always_comb begin
		mode_d = mode_q;
		if (end_of_input) begin
			mode_d = M_SKIP;
		end else begin
			case (mode_q)
				M_LEADCOM: begin
					mode_d = (in_char == CH_NL) ? M_SKIP : M_LEADCOM;
				end
				M_NAME: begin
					mode_d = name_next(in_char);
				end
				M_SPACES: begin
					mode_d = (in_char == CH_SPACE) ? M_SPACES : name_next(in_char);
				end
				M_PERIOD: begin
					if (in_char == CH_PIPE) begin
						mode_d = M_TAILCOM;
					end else if (is_blank(in_char)) begin
						mode_d = M_SKIP;
					end else if (in_char == CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else begin
						mode_d = M_NAME;
					end
				end
				M_ESCAPE: begin
					mode_d = (in_char == CH_SPACE) ? M_SPACES : M_NAME;
				end
				M_TAILCOM: begin
					mode_d = (in_char == CH_NL) ? M_SKIP : M_TAILCOM;
				end
				default: begin
					if (in_char == CH_PIPE) begin
						mode_d = M_LEADCOM;
					end else if (is_blank(in_char)) begin
						mode_d = M_SKIP;
					end else begin
						mode_d = name_next(in_char);
					end
				end
			endcase
		end
	end

	// actions per byte; the period is written ahead and only counted once kept
	always_comb begin
		dot_commit = 1'b0;
		spec_dot   = 1'b0;
		app_en     = 1'b0;
		fin        = 1'b0;
		found      = 1'b1;
		code       = DLM_EOI;
		if (end_of_input) begin
			fin = 1'b1;
			case (mode_q)
				M_NAME, M_SPACES, M_ESCAPE, M_TAILCOM: found = 1'b1;
				M_PERIOD:                              dot_commit = 1'b1;
				default:                               found = 1'b0;
			endcase
		end else begin
			case (mode_q)
				M_LEADCOM: begin
				end
				M_PERIOD: begin
					if (in_char == CH_SPACE) begin
						fin  = 1'b1;
						code = DLM_SPACE;
					end else if (in_char == CH_TAB) begin
						fin  = 1'b1;
						code = DLM_TAB;
					end else if (in_char == CH_NL) begin
						fin  = 1'b1;
						code = DLM_NL;
					end else if (in_char != CH_PIPE) begin
						dot_commit = 1'b1;
						app_en     = (in_char != CH_BSLASH);
					end
				end
				M_ESCAPE: begin
					app_en = 1'b1;
				end
				M_TAILCOM: begin
					if (in_char == CH_NL) begin
						fin  = 1'b1;
						code = DLM_NL;
					end
				end
				default: begin
					// skip, name, spaces: only bytes that reach name handling
					if (mode_q == M_SPACES && in_char == CH_SPACE) begin
					end else if (mode_q != M_NAME && mode_q != M_SPACES &&
							(in_char == CH_PIPE || is_blank(in_char))) begin
					end else if (in_char == CH_COLON) begin
						fin  = 1'b1;
						code = DLM_COLON;
					end else if (in_char == CH_COMMA) begin
						fin  = 1'b1;
						code = DLM_COMMA;
					end else if (in_char == CH_NL) begin
						fin  = 1'b1;
						code = DLM_NL;
					end else if (in_char == CH_PERIOD) begin
						spec_dot = 1'b1;
					end else if (in_char != CH_PIPE && in_char != CH_BSLASH) begin
						app_en = 1'b1;
					end
				end
			endcase
		end
	end

	// length bookkeeping and buffer write
	always_comb begin
		k1    = kept_q;
		nb1   = nb_q;
		ov1   = ovf_q;
		wr_ok = 1'b0;
		if (dot_commit) begin
			if (k1 < MAXC) begin
				nb1 = CW'(k1 + 1'b1);
				k1  = CW'(k1 + 1'b1);
			end else begin
				ov1 = 1'b1;
			end
		end
		wr_idx = spec_dot ? kept_q : k1;
		if (app_en) begin
			if (k1 < MAXC) begin
				wr_ok = 1'b1;
				if (!is_blank(in_char)) nb1 = CW'(k1 + 1'b1);
				k1 = CW'(k1 + 1'b1);
			end else if (!is_blank(in_char)) begin
				ov1 = 1'b1;
			end
		end
		if (spec_dot && kept_q < MAXC) wr_ok = 1'b1;
	end

	assign wr_en   = accept && wr_ok;
	assign wr_data = spec_dot ? CH_PERIOD : in_char;
	assign wr_addr = bank_q ? AW'(BANK_OFS + AW'(wr_idx)) : AW'(wr_idx);

	assign job_n          = found ? nb1 : '0;
	assign job_meta.delim = code;
	assign job_meta.found = found;
	assign job_meta.trunc = found ? ov1 : 1'b0;
	assign job_meta.bank  = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SKIP;
			kept_q <= '0;
			nb_q   <= '0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			if (fin) begin
				kept_q <= '0;
				nb_q   <= '0;
				ovf_q  <= 1'b0;
				bank_q <= ~bank_q;
			end else begin
				kept_q <= k1;
				nb_q   <= nb1;
				ovf_q  <= ov1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/aft_emitter.sv
`default_nettype none
module aft_emitter #(
	parameter int MAX_NAME_CHARS = 32,
	parameter int CW = $clog2(MAX_NAME_CHARS + 1),
	parameter int AW = $clog2(2 * MAX_NAME_CHARS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [7:0]            wr_data,
	input  wire logic                  fin,
	input  wire logic [CW-1:0]         job_n,
	input  wire aft_pkg::job_meta_t    job_meta,
	output logic                       job_full,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 token_char,
	output logic                       char_valid,
	output logic                       last,
	output logic [2:0]                 delimiter,
	output logic                       found_token,
	output logic                       truncated
);
	import aft_pkg::*;

	localparam int DEPTH = 2 * MAX_NAME_CHARS;
	localparam logic [AW-1:0] BANK_OFS = AW'(MAX_NAME_CHARS);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	logic          pend_valid_q;
	logic [CW-1:0] pend_n_q;
	job_meta_t     pend_meta_q;

	logic          act_valid_q;
	logic [CW-1:0] act_n_q, act_idx_q;
	job_meta_t     act_meta_q;

	logic          s1_valid_s1, s1_chv_s1, s1_last_s1;
	job_meta_t     s1_meta_s1;

	logic          out_valid_q;

	logic          s1_move, issue, last_issue, take_job;
	logic [CW:0]   idx_next;
	logic [AW-1:0] rd_addr;

	assign s1_move    = !out_valid_q || !out_stall;
	assign issue      = act_valid_q && (!s1_valid_s1 || s1_move);
	assign idx_next   = {1'b0, act_idx_q} + 1'b1;
	assign last_issue = idx_next >= {1'b0, act_n_q};
	assign take_job   = (!act_valid_q || (issue && last_issue)) && (pend_valid_q || fin);
	assign rd_addr    = act_meta_q.bank ? AW'(BANK_OFS + AW'(act_idx_q)) : AW'(act_idx_q);
	assign job_full   = pend_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (issue) rdata_q <= mem[rd_addr];
	end

	// finished name waiting for the emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (fin && !take_job) begin
			pend_valid_q <= 1'b1;
		end else if (take_job) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && !take_job) begin
			pend_n_q    <= job_n;
			pend_meta_q <= job_meta;
		end
	end

	// active name: walk its characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
			act_idx_q   <= '0;
		end else if (take_job) begin
			act_valid_q <= 1'b1;
			act_idx_q   <= '0;
		end else if (issue) begin
			act_valid_q <= !last_issue;
			act_idx_q   <= idx_next[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take_job) begin
			act_n_q    <= pend_valid_q ? pend_n_q : job_n;
			act_meta_q <= pend_valid_q ? pend_meta_q : job_meta;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (issue) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_chv_s1  <= (act_n_q != '0);
			s1_last_s1 <= last_issue;
			s1_meta_s1 <= act_meta_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_valid_s1) begin
			token_char  <= s1_chv_s1 ? rdata_q : 8'h00;
			char_valid  <= s1_chv_s1;
			last        <= s1_last_s1;
			delimiter   <= s1_meta_s1.delim;
			found_token <= s1_meta_s1.found;
			truncated   <= s1_meta_s1.trunc;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: src/attribute_file_tokenizer_top.sv
// Name tokenizer for attribute files.
// Input channel: one byte per request (in_char), or an end marker (end_of_input),
// handshaked by in_valid / in_stall. Output channel: one request per character
// of each finished name (one with char_valid low if empty), with last set on
// the final one and the delimiter code, found_token and truncated repeated on
// every request of the name. Bytes are parsed at one per cycle unless input
// stalls. A name is stored in a two-bank buffer memory; when it ends, the
// emitter reads it back one character per cycle unless output stalls, through
// a registered read and an output register as the parser fills the other bank.
// Input stalls as soon as a name finishes while the emitter is still reading out
// an earlier one; it then waits until that earlier name's last read is issued.
// Sustained rate: one byte per cycle as long as names are emitted no slower
// than they arrive, bound by the single read port of the buffer memory.
// Output stall holds the output register and backs up reads and then input.
// Reset puts the parser in blank skipping with empty counters and clears all
// valid flags; buffer contents are not cleared and need no clearing pass.
`default_nettype none
module attribute_file_tokenizer_top #(
	parameter int MAX_NAME_CHARS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      token_char,
	output logic            char_valid,
	output logic            last,
	output logic [2:0]      delimiter,
	output logic            found_token,
	output logic            truncated
);
	import aft_pkg::*;

	localparam int CW = $clog2(MAX_NAME_CHARS + 1);
	localparam int AW = $clog2(2 * MAX_NAME_CHARS);

	logic          accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          fin;
	logic [CW-1:0] job_n;
	job_meta_t     job_meta;
	logic          job_full;

	// while a finished name waits, the parser's next bank is still being read out
	assign in_stall = job_full;
	assign accept   = in_valid && !job_full;

	aft_parser #(
		.MAX_NAME_CHARS(MAX_NAME_CHARS),
		.CW(CW),
		.AW(AW)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_char(in_char),
		.end_of_input(end_of_input),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.fin(fin),
		.job_n(job_n),
		.job_meta(job_meta)
	);

	aft_emitter #(
		.MAX_NAME_CHARS(MAX_NAME_CHARS),
		.CW(CW),
		.AW(AW)
	) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.fin(fin && accept),
		.job_n(job_n),
		.job_meta(job_meta),
		.job_full(job_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_char(token_char),
		.char_valid(char_valid),
		.last(last),
		.delimiter(delimiter),
		.found_token(found_token),
		.truncated(truncated)
	);

endmodule
`default_nettype wire
